// ===== hw/rtl/bstbp_pkg.sv =====
// bstbp_pkg: shared types and constants for the preorder bst builder
// used by the top level and the testbench; depends on nothing
package bstbp_pkg;

  localparam int NUM_W = 10;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DUP  = 2'd1,
    ERR_FULL = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WAIT
  } state_t;

endpackage

// ===== hw/rtl/bstbp_ram.sv =====
// bstbp_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module bstbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bst_build_from_preorder.sv =====
// bst_build_from_preorder: links preorder keys into a bst one beat at a time
// a key is taken in S_IDLE and resolved in S_CMP; each ancestor popped passes through S_WAIT
// no new key is taken until the last result is registered; each pop waits on the stack ram read
// output register holds one result while the next key is taken; a stalled result holds the loop
// synchronous reset clears control state; the stack ram is not cleared
// depends on bstbp_pkg and bstbp_ram
module bst_build_from_preorder #(
  parameter int MAX_NODES = 1024,
  parameter int KEY_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [KEY_BITS-1:0]    key,
  input  logic                          start_tree,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bstbp_pkg::NUM_W-1:0]   node_number,
  output logic [bstbp_pkg::NUM_W-1:0]   parent_number,
  output logic                          is_right_child,
  output logic                          is_root,
  output bstbp_pkg::err_t               error_code
);
  import bstbp_pkg::*;

  localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int MW    = KEY_BITS + AW;

  state_t state, state_next;

  logic [KEY_BITS-1:0] k;
  logic                start_q;
  logic [KEY_BITS-1:0] cur_key;
  logic [AW-1:0]       cur_num;
  logic [CNT_W-1:0]    sp;
  logic [CNT_W-1:0]    node_count;
  logic                started;

  logic [CNT_W-1:0]    sp_m1;
  logic [MW-1:0]       rd_data;
  logic [KEY_BITS-1:0] top_key;
  logic [AW-1:0]       top_num;

  logic accept, out_free;
  logic do_root, lt, gt, eq, top_lt, sp_zero, place, full, dup, pop, finish, fire;
  logic push;

  logic [NUM_W-1:0] res_num, res_parent;
  logic             res_right, res_root;
  err_t             res_err;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sp_m1    = sp - CNT_W'(1);
  assign top_key  = rd_data[MW-1:AW];
  assign top_num  = rd_data[AW-1:0];

  // shared compare unit
  assign lt      = k < cur_key;
  assign gt      = k > cur_key;
  assign eq      = !lt && !gt;
  assign top_lt  = k < top_key;
  assign sp_zero = (sp == '0);
  assign do_root = start_q || !started;
  assign place   = !do_root && (lt || (gt && (sp_zero || top_lt)));
  assign full    = node_count >= CNT_W'(MAX_NODES);
  assign dup     = !do_root && !place && (eq || sp_zero);
  assign pop     = !do_root && !place && !dup;
  assign finish  = do_root || place || dup;
  assign fire    = (state == S_CMP) && finish && out_free;

  bstbp_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_NODES)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (sp[AW-1:0]),
    .wdata ({cur_key, cur_num}),
    .raddr (sp_m1[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: begin
        if (pop) state_next = S_WAIT;
        else if (fire) state_next = S_IDLE;
      end
      S_WAIT: state_next = S_CMP;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    push       = fire && place && !full && lt && (sp < CNT_W'(MAX_NODES));
    res_num    = '0;
    res_parent = '0;
    res_right  = 1'b0;
    res_root   = 1'b0;
    res_err    = ERR_NONE;
    if (do_root) begin
      res_root = 1'b1;
    end else if (place && full) begin
      res_err = ERR_FULL;
    end else if (place) begin
      res_num    = NUM_W'(node_count);
      res_parent = NUM_W'(cur_num);
      res_right  = !lt;
    end else begin
      res_err = ERR_DUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sp         <= '0;
      cur_key    <= '0;
      cur_num    <= '0;
      node_count <= '0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_CMP && pop) begin
        sp      <= sp_m1;
        cur_key <= top_key;
        cur_num <= top_num;
      end
      if (fire && do_root) begin
        started    <= 1'b1;
        sp         <= '0;
        cur_key    <= k;
        cur_num    <= '0;
        node_count <= CNT_W'(1);
      end else if (fire && place && !full) begin
        node_count <= node_count + CNT_W'(1);
        cur_key    <= k;
        cur_num    <= node_count[AW-1:0];
        if (push) sp <= sp + CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      k       <= {~key[KEY_BITS-1], key[KEY_BITS-2:0]};
      start_q <= start_tree;
    end
    if (fire) begin
      node_number    <= res_num;
      parent_number  <= res_parent;
      is_right_child <= res_right;
      is_root        <= res_root;
      error_code     <= res_err;
    end
  end

endmodule

// ===== hw/rtl/bstbp_checker.sv =====
// bstbp_checker: port-level checks on the preorder bst builder
// depends on nothing; bound to bst_build_from_preorder below
module bstbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] node_number,
  input logic [9:0] parent_number,
  input logic       is_right_child,
  input logic       is_root,
  input logic [1:0] error_code
);

  // one key at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a key is in progress");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code != 2'd3))
    else $error("unknown error code");

  a_root: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_root) |-> (node_number == 10'd0 && parent_number == 10'd0 &&
                                !is_right_child && error_code == 2'd0))
    else $error("root beat with bad fields");

  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != 2'd0) |-> (node_number == 10'd0 &&
      parent_number == 10'd0 && !is_right_child && !is_root))
    else $error("rejected beat with nonzero fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(node_number) &&
                                   $stable(error_code)))
    else $error("stalled result beat changed");

endmodule

bind bst_build_from_preorder bstbp_checker u_bstbp_checker (.*);

// ===== tb/testbench.sv =====
// testbench for bst_build_from_preorder: drives preorder key beats with random stalls on both
// channels and checks every link result against an in-bench model of the stack construction
// depends on bstbp_pkg and the bst_build_from_preorder rtl
`timescale 1ns / 1ps

module testbench;
  import bstbp_pkg::*;

  localparam int MAX_NODES = 1024;
  localparam int KEY_W     = 16;

  typedef struct {
    logic [NUM_W-1:0] node;
    logic [NUM_W-1:0] parent;
    logic             right;
    logic             root;
    err_t             err;
  } link_t;

  class link_tracker;
    logic signed [KEY_W-1:0] anc_key [MAX_NODES];
    logic [NUM_W-1:0]        anc_num [MAX_NODES];
    int                      sp;
    int                      count;
    logic signed [KEY_W-1:0] cur_key;
    logic [NUM_W-1:0]        cur_num;
    bit                      started;
    link_t                   pending [$];
    int                      failures;
    int                      n_linked;
    int                      n_roots;
    int                      n_dup;
    int                      n_full;

    function void clear();
      sp = 0;
      count = 0;
      cur_key = '0;
      cur_num = '0;
      started = 0;
    endfunction

    // works out where an accepted key lands and queues the link it should produce
    function void note_key(logic signed [KEY_W-1:0] k, bit st);
      link_t r;
      bit    done;
      bit    go_left;
      bit    go_right;
      r.node = '0;
      r.parent = '0;
      r.right = 1'b0;
      r.root = 1'b0;
      r.err = ERR_NONE;
      if (st || !started) begin
        started = 1;
        sp = 0;
        cur_key = k;
        cur_num = '0;
        count = 1;
        r.root = 1'b1;
      end else begin
        done = 0;
        while (!done) begin
          go_left = k < cur_key;
          go_right = 0;
          if (!go_left && k > cur_key)
            go_right = (sp == 0) || (k < anc_key[sp-1]);
          if (go_left || go_right) begin
            if (count >= MAX_NODES) begin
              r.err = ERR_FULL;
            end else begin
              r.node = count[NUM_W-1:0];
              r.parent = cur_num;
              r.right = go_right;
              count++;
              if (go_left && sp < MAX_NODES) begin
                anc_key[sp] = cur_key;
                anc_num[sp] = cur_num;
                sp++;
              end
              cur_key = k;
              cur_num = r.node;
            end
            done = 1;
          end else if (k == cur_key || sp == 0) begin
            r.err = ERR_DUP;
            done = 1;
          end else begin
            sp--;
            cur_key = anc_key[sp];
            cur_num = anc_num[sp];
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_link(logic [NUM_W-1:0] node, logic [NUM_W-1:0] parent,
                             logic right, logic root, err_t err);
      link_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: node_number %0d error_code %0d", node, err);
        failures++;
        return;
      end
      e = pending.pop_front();
      cmp("node_number", e.node, node);
      cmp("parent_number", e.parent, parent);
      cmp("is_right_child", e.right, right);
      cmp("is_root", e.root, root);
      cmp("error_code", e.err, err);
      case (e.err)
        ERR_DUP:  n_dup++;
        ERR_FULL: n_full++;
        default: begin
          if (e.root) n_roots++;
          else n_linked++;
        end
      endcase
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [KEY_W-1:0] key;
  logic                    start_tree;
  logic                    out_valid;
  logic                    out_ready;
  logic [NUM_W-1:0]        node_number;
  logic [NUM_W-1:0]        parent_number;
  logic                    is_right_child;
  logic                    is_root;
  err_t                    error_code;

  link_tracker links;
  bit          calm = 0;
  int          n_keys = 0;

  bst_build_from_preorder #(
    .MAX_NODES(MAX_NODES),
    .KEY_BITS (KEY_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .key           (key),
    .start_tree    (start_tree),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .node_number   (node_number),
    .parent_number (parent_number),
    .is_right_child(is_right_child),
    .is_root       (is_root),
    .error_code    (error_code)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      links.check_link(node_number, parent_number, is_right_child, is_root, error_code);
  end

  // returns at the rising edge where the beat is taken
  task automatic send_key(input int k, input bit st);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    key <= k[KEY_W-1:0];
    start_tree <= st;
    do @(posedge clk); while (!in_ready);
    links.note_key(k[KEY_W-1:0], st);
    n_keys++;
  endtask

  // mostly whole preorder sequences of random trees, plus noise and broken sequences
  task automatic run_random(input int n_items);
    int pool [$];
    int sorted [$];
    int seq [$];
    int lo_q [$];
    int hi_q [$];
    int sent;
    int kind;
    int size;
    int lo;
    int hi;
    int m;
    int a;
    int b;
    int tmp;
    bit narrow;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_key(int'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
          sent++;
        end
      end else begin
        narrow = $urandom_range(0, 2) == 0;
        size = $urandom_range(1, narrow ? 30 : 40);
        pool.delete();
        repeat (size)
          pool.push_back(narrow ? int'($urandom_range(0, 40)) - 20
                                : int'($urandom_range(0, 65535)) - 32768);
        if (!narrow && $urandom_range(0, 3) == 0) begin
          pool.push_back(32767);
          pool.push_back(-32768);
        end
        pool.sort();
        sorted.delete();
        foreach (pool[i])
          if (i == 0 || pool[i] != pool[i-1]) sorted.push_back(pool[i]);
        seq.delete();
        lo_q.delete();
        hi_q.delete();
        lo_q.push_back(0);
        hi_q.push_back(sorted.size() - 1);
        while (lo_q.size() != 0) begin
          lo = lo_q.pop_back();
          hi = hi_q.pop_back();
          if (lo > hi) continue;
          m = $urandom_range(lo, hi);
          seq.push_back(sorted[m]);
          lo_q.push_back(m + 1);
          hi_q.push_back(hi);
          lo_q.push_back(lo);
          hi_q.push_back(m - 1);
        end
        if (kind == 7) begin
          a = $urandom_range(0, seq.size() - 1);
          b = $urandom_range(0, seq.size() - 1);
          if ($urandom_range(0, 1)) begin
            tmp = seq[a];
            seq[a] = seq[b];
            seq[b] = tmp;
          end else begin
            seq.insert(b, seq[a]);
          end
        end
        foreach (seq[i]) begin
          send_key(seq[i], i == 0 && kind != 6);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int guard;
    links = new;
    links.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    key = '0;
    start_tree = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first key roots the tree even without the start flag
    send_key(0, 0);
    send_key(32767, 0);
    send_key(32767, 0);
    send_key(-32768, 1);
    send_key(32767, 0);
    send_key(-32768, 0);
    // pops before a right link
    send_key(100, 1);
    send_key(50, 0);
    send_key(25, 0);
    send_key(75, 0);
    send_key(200, 0);
    // duplicate found after a pop; the pop is kept
    send_key(10, 1);
    send_key(5, 0);
    send_key(10, 0);
    send_key(20, 0);
    // out of order key is linked left unchecked
    send_key(10, 1);
    send_key(20, 0);
    send_key(5, 0);
    send_key(0, 1);
    send_key(-1, 0);
    send_key(1, 0);
    send_key(-1, 0);

    run_random(460);

    calm = 1;
    run_random(100);
    @(negedge clk);
    in_valid <= 1'b0;

    guard = 0;
    while (links.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (links.pending.size() != 0) begin
      $error("%0d expected results never arrived", links.pending.size());
      links.failures++;
    end

    $display("%0d key beats: %0d roots, %0d linked nodes, %0d duplicates, %0d table-full",
             n_keys, links.n_roots, links.n_linked, links.n_dup, links.n_full);
    $display("directed and random preorder trees with stalls on both sides, %0d mismatches",
             links.failures);
    if (links.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
